// ----- hw/rtl/svft_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sorted value frequency table.
// Used by svft_cell, sorted_value_frequency_table and the testbench.
package svft_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // One table slot: occupancy, key and occurrence count
  typedef struct packed {
    logic                     valid;
    logic signed [KeyW-1:0]   key;
    logic        [CountW-1:0] count;
  } entry_t;

  // Per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic hit_en;   // a key transaction is presented for matching
    logic ins_en;   // the key is new and there is room: open a slot
    logic shift_en; // drain: hand every entry one cell towards the head
  } cell_ctl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_e;

endpackage

// ----- hw/rtl/svft_cell.sv -----
`timescale 1ns / 1ps
// One cell of the sorted chain: holds a single key/count entry.
// Depends on svft_pkg for entry_t and cell_ctl_t.
module svft_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  svft_pkg::cell_ctl_t      ctl_i,
  input  logic signed [31:0]       key_i,
  input  svft_pkg::entry_t         prev_ent_i,
  input  logic                     prev_gt_i,
  input  svft_pkg::entry_t         next_ent_i,
  output svft_pkg::entry_t         ent_o,
  output logic                     gt_o,
  output logic                     hit_o
);
  import svft_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [KeyW-1:0]   key_q, key_d;
  logic        [CountW-1:0] count_q, count_d;

  assign ent_o = '{valid: valid_q, key: key_q, count: count_q};
  assign gt_o  = valid_q && (key_q > key_i);
  assign hit_o = valid_q && (key_q == key_i);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    count_d = count_q;
    if (ctl_i.shift_en) begin
      valid_d = next_ent_i.valid;
      key_d   = next_ent_i.key;
      count_d = next_ent_i.count;
    end else if (ctl_i.hit_en && hit_o) begin
      if (count_q != COUNT_MAX) begin
        count_d = count_q + CountW'(1);
      end
    end else if (ctl_i.ins_en) begin
      if (prev_gt_i) begin
        // make room: take the left neighbour's entry
        valid_d = prev_ent_i.valid;
        key_d   = prev_ent_i.key;
        count_d = prev_ent_i.count;
      end else if (prev_ent_i.valid && (gt_o || !valid_q)) begin
        valid_d = 1'b1;
        key_d   = key_i;
        count_d = CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    count_q <= count_d;
  end

endmodule

// ----- hw/rtl/sorted_value_frequency_table.sv -----
`timescale 1ns / 1ps
// Channel | direction | fields
// in      | slave     | key_value_i, last_in_set_i       (in_valid_i / in_stall_o)
// out     | master    | distinct_key_o, occurrences_o,
//         |           | overflowed_o, last_result_o      (out_valid_o / out_stall_i)
// Keys enter one per cycle while input is not stalled; a chain of MAX_DISTINCT
// cells keeps them sorted by compare-and-shift. After the last key the chain
// drains one result per cycle from the head cell while out_stall_i is low;
// input is stalled meanwhile. Reset clears all cell valid bits and the
// overflow flag at once.
// Depends on svft_pkg and svft_cell.
module sorted_value_frequency_table #(
  parameter int unsigned MAX_DISTINCT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] key_value_i,
  input  logic               last_in_set_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] distinct_key_o,
  output logic [15:0]        occurrences_o,
  output logic               overflowed_o,
  output logic               last_result_o
);
  import svft_pkg::*;

  state_e    state_q, state_d;
  logic      overflow_q, overflow_d;
  cell_ctl_t ctl;
  logic      in_acc, out_acc, hit_any, full;

  entry_t                  ent      [MAX_DISTINCT];
  entry_t                  prev_ent [MAX_DISTINCT];
  entry_t                  next_ent [MAX_DISTINCT];
  logic [MAX_DISTINCT-1:0] gt, hit, prev_gt;

  for (genvar g = 0; g < MAX_DISTINCT; g++) begin : g_chain
    if (g == 0) begin : g_head
      // a virtual valid entry in front of the head, treated as not greater than the key
      assign prev_ent[g] = '{valid: 1'b1, key: '0, count: '0};
      assign prev_gt[g]  = 1'b0;
    end else begin : g_body
      assign prev_ent[g] = ent[g-1];
      assign prev_gt[g]  = gt[g-1];
    end
    if (g == MAX_DISTINCT - 1) begin : g_tail
      assign next_ent[g] = '{valid: 1'b0, key: '0, count: '0};
    end else begin : g_mid
      assign next_ent[g] = ent[g+1];
    end

    svft_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .key_i      (key_value_i),
      .prev_ent_i (prev_ent[g]),
      .prev_gt_i  (prev_gt[g]),
      .next_ent_i (next_ent[g]),
      .ent_o      (ent[g]),
      .gt_o       (gt[g]),
      .hit_o      (hit[g])
    );
  end

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign hit_any = |hit;
  assign full    = ent[MAX_DISTINCT-1].valid;

  assign ctl.hit_en   = in_acc;
  assign ctl.ins_en   = in_acc && !hit_any && !full;
  assign ctl.shift_en = out_acc;

  assign distinct_key_o = ent[0].key;
  assign occurrences_o  = ent[0].count;
  assign overflowed_o   = overflow_q;
  assign last_result_o  = !ent[1].valid;

  always_comb begin
    state_d     = state_q;
    overflow_d  = overflow_q;
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_acc && !hit_any && full) begin
          overflow_d = 1'b1;
        end
        if (in_acc && last_in_set_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        in_stall_o  = 1'b1;
        out_valid_o = ent[0].valid;
        // leave once the final entry has gone
        if (!ent[0].valid || (out_acc && !ent[1].valid)) begin
          state_d    = ST_COLLECT;
          overflow_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_COLLECT;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

endmodule

// ----- hw/rtl/svft_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for sorted_value_frequency_table, bound to the top level.
// Depends only on the top level's ports.
module svft_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               last_in_set_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] distinct_key_o,
  input logic               overflowed_o,
  input logic               last_result_o
);

  // no key transaction is taken while results are being emitted
  a_no_input_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while results pending");

  // a set's last key is followed by its first result
  a_last_starts_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_in_set_i) |=> out_valid_o)
    else $error("no result after last key of set");

  // results of one set come in strictly ascending key order
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_result_o) |=>
      (out_valid_o && (distinct_key_o > $past(distinct_key_o))))
    else $error("result keys out of order");

  // the overflow flag is the same on every result of a set
  a_overflow_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_result_o) |=> (!out_valid_o || $stable(overflowed_o)))
    else $error("overflow flag changed within a set");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(distinct_key_o)))
    else $error("stalled result changed");

endmodule

bind sorted_value_frequency_table svft_checker u_svft_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .last_in_set_i  (last_in_set_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .distinct_key_o (distinct_key_o),
  .overflowed_o   (overflowed_o),
  .last_result_o  (last_result_o)
);

// ----- sim/sorted_value_frequency_table_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_value_frequency_table: predicts each emitted
// table from the accepted key transactions and checks every result field.
// Depends on svft_pkg and the sorted_value_frequency_table RTL.
module sorted_value_frequency_table_tb;
  import svft_pkg::*;

  localparam int unsigned MaxDistinct = 64;
  localparam int unsigned DrainSlack  = 2 * MaxDistinct + 20;

  typedef struct packed {
    logic signed [KeyW-1:0]   key;
    logic        [CountW-1:0] count;
    logic                     overflowed;
    logic                     last;
  } table_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [KeyW-1:0]   key_value_i;
  logic                     last_in_set_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [KeyW-1:0]   distinct_key_o;
  logic        [CountW-1:0] occurrences_o;
  logic                     overflowed_o;
  logic                     last_result_o;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;

  // Running tally of the open set, in arrival order
  logic signed [KeyW-1:0]   seen_keys[$];
  logic        [CountW-1:0] seen_counts[$];
  logic                     keys_dropped;
  // Sorted rows still to come out of the block
  table_row_t               pending_rows[$];

  sorted_value_frequency_table #(
    .MAX_DISTINCT(MaxDistinct)
  ) u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .key_value_i,
    .last_in_set_i,
    .out_valid_o,
    .out_stall_i,
    .distinct_key_o,
    .occurrences_o,
    .overflowed_o,
    .last_result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end

  // Count one key; on the last of a set, queue the table sorted by signed key
  function automatic void tally_key(input logic signed [KeyW-1:0] key, input logic last);
    int         slot;
    int         j;
    table_row_t row;
    table_row_t rows[$];
    slot = -1;
    foreach (seen_keys[i]) begin
      if (seen_keys[i] == key) slot = i;
    end
    if (slot >= 0) begin
      if (seen_counts[slot] != COUNT_MAX) seen_counts[slot] = seen_counts[slot] + 1'b1;
    end else if (seen_keys.size() < MaxDistinct) begin
      seen_keys.push_back(key);
      seen_counts.push_back(CountW'(1));
    end else begin
      keys_dropped = 1'b1;
    end
    if (!last) return;
    foreach (seen_keys[i]) begin
      row.key        = seen_keys[i];
      row.count      = seen_counts[i];
      row.overflowed = keys_dropped;
      row.last       = 1'b0;
      j = rows.size();
      rows.push_back(row);
      while (j > 0 && $signed(rows[j-1].key) > $signed(row.key)) begin
        rows[j] = rows[j-1];
        j--;
      end
      rows[j] = row;
    end
    rows[rows.size()-1].last = 1'b1;
    foreach (rows[i]) pending_rows.push_back(rows[i]);
    seen_keys.delete();
    seen_counts.delete();
    keys_dropped = 1'b0;
  endfunction

  // Present one key transaction; valid stays high on return for a back-to-back follow-up
  task automatic send_key(input logic signed [KeyW-1:0] key, input logic last);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    key_value_i   <= key;
    last_in_set_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    tally_key(key, last);
  endtask

  // Drop valid and hold until every queued row has come out
  task automatic idle_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    table_row_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rows.size() == 0) begin
        $error("Result with nothing pending: distinct_key %0d occurrences %0d",
               distinct_key_o, occurrences_o);
        mismatch_count++;
      end else begin
        want = pending_rows.pop_front();
        if (distinct_key_o !== want.key) begin
          $error("distinct_key: expected %0d, actual %0d", $signed(want.key), distinct_key_o);
          mismatch_count++;
        end
        if (occurrences_o !== want.count) begin
          $error("occurrences: expected %0d, actual %0d", want.count, occurrences_o);
          mismatch_count++;
        end
        if (overflowed_o !== want.overflowed) begin
          $error("overflowed: expected %0b, actual %0b", want.overflowed, overflowed_o);
          mismatch_count++;
        end
        if (last_result_o !== want.last) begin
          $error("last_result: expected %0b, actual %0b", want.last, last_result_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed_extremes();
    logic signed [KeyW-1:0] mixed_keys[10] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
      32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'hFFFF_FFFF
    };
    // Single-key set
    send_key(0, 1'b1);
    // Extremes and alternating patterns, closed by a repeated key
    foreach (mixed_keys[i]) send_key(mixed_keys[i], i == 9);
    send_key(7, 1'b0);
    send_key(7, 1'b0);
    send_key(7, 1'b1);
    // Reverse order on arrival
    for (int v = 5; v >= 1; v--) send_key(v, v == 1);
  endtask

  task automatic test_table_capacity();
    logic signed [KeyW-1:0] fill_keys[MaxDistinct];
    // Distinct top bits guarantee distinct keys
    foreach (fill_keys[i]) fill_keys[i] = {6'(i), 26'($urandom)};
    // Fill every slot in scrambled order and keep the set open
    for (int j = 0; j < MaxDistinct; j++) begin
      send_key(fill_keys[(j * 37) % MaxDistinct], 1'b0);
    end
    // Full table: new keys dropped, a repeat still counted, the closing key dropped too
    send_key(fill_keys[0] ^ 32'h1, 1'b0);
    send_key(fill_keys[5], 1'b0);
    send_key(fill_keys[9] ^ 32'h100, 1'b1);
    // The flag must not carry into the next set
    send_key(fill_keys[3], 1'b0);
    send_key(fill_keys[3], 1'b1);
  endtask

  task automatic test_random_sets(input int n_items);
    int                     sent;
    int                     set_len;
    bit                     first_set;
    logic signed [KeyW-1:0] key;
    sent      = 0;
    first_set = 1'b1;
    while (sent < n_items) begin
      set_len = ($urandom_range(7) == 0) ? $urandom_range(15, 35) : $urandom_range(1, 8);
      for (int i = 0; i < set_len; i++) begin
        case ($urandom_range(9))
          0, 1: key = $urandom;
          2: begin
            case ($urandom_range(3))
              0:       key = 32'h8000_0000;
              1:       key = 32'h7FFF_FFFF;
              2:       key = 32'hFFFF_FFFF;
              default: key = 0;
            endcase
          end
          default: begin
            // Narrow pool so that keys repeat
            key = $urandom_range(11);
            key = key - 6;
          end
        endcase
        send_key(key, i == set_len - 1);
      end
      sent += set_len;
      // Hold off once per call until the table has drained
      if (first_set) idle_until_drained();
      first_set = 1'b0;
    end
  endtask

  initial begin
    mismatch_count = 0;
    send_idle_pct  = 27;
    recv_idle_pct  = 58;
    keys_dropped   = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    key_value_i    = '0;
    last_in_set_i  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_extremes();
    test_random_sets(12);
    idle_until_drained();

    send_idle_pct = 58;
    recv_idle_pct = 27;
    test_table_capacity();
    test_random_sets(12);
    idle_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sets(12);
    idle_until_drained();

    // Let any stray result show up
    repeat (DrainSlack) @(posedge clk_i);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/svft_pkg.sv
hw/rtl/svft_cell.sv
hw/rtl/sorted_value_frequency_table.sv
hw/rtl/svft_checker.sv
sim/sorted_value_frequency_table_tb.sv
